[hdl/gff_pkg.sv]
// Shared types and constants for the grid flood-fill block.
// Used by grid_flood_fill; depends on nothing else.
`default_nettype none

package gff_pkg;

  // Grid geometry: row and column fields are six bits each.
  localparam int RowBits  = 6;
  localparam int ColBits  = 6;
  localparam int AddrBits = RowBits + ColBits;
  localparam int Cells    = 1 << AddrBits;
  localparam int MaxRows  = 1 << RowBits;
  localparam int MaxCols  = 1 << ColBits;
  localparam int IdBits   = 16;
  localparam int CntBits  = AddrBits + 1;
  localparam int ExtBits  = 7;

  // Operation carried in the request sideband.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLOOD = 2'd2
  } func_e;

  // Register index taken from the configuration address.
  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

  // Neighbours in the order they are visited.
  localparam logic [1:0] NbLeft  = 2'd0;
  localparam logic [1:0] NbRight = 2'd1;
  localparam logic [1:0] NbUp    = 2'd2;
  localparam logic [1:0] NbDown  = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_POP,
    ST_DEQ,
    ST_NREAD,
    ST_NCHECK
  } state_e;

  // A grid position; packed so that it doubles as the memory address.
  typedef struct packed {
    logic [RowBits-1:0] row;
    logic [ColBits-1:0] col;
  } pos_t;

endpackage

`default_nettype wire

[hdl/gff_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used by grid_flood_fill for the tile grid and the fill queue.
`default_nettype none

module gff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/grid_flood_fill.sv]
// Top level of the grid flood-fill block: request decode, flood sequencer,
// clearing pass and configuration registers. Depends on gff_pkg and gff_ram.
//
// A 64 x 64 grid of 16-bit tile ids is held in a synchronous RAM; a second RAM
// holds the breadth-first fill queue. Reads, writes and the unused operation
// code do not leave the idle state, so such requests are accepted back to back
// while the result slot drains. A flood reads the start tile, then for every
// replaced tile pops it from the queue and reads and checks in turn each of
// its neighbours inside the extent, and at last posts the count; a flood that
// is outside the extent is answered at once, and one onto the same id after
// the start tile is read. The single read port of the tile RAM makes these
// steps run one after another.
// After reset, and after every write to an extent register, a clearing pass
// sweeps all 4096 tiles of the tile RAM (zeroing all of it after reset, and the
// tiles outside the extent after a register write); no request is accepted
// during the pass, while register writes are taken as usual.
`default_nettype none

module grid_flood_fill (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: row[5:0], col[11:6], tile_value[27:12], zero fill [31:28].
  input  wire logic [31:0] s_axis_tdata,
  // tuser from bit 0: func[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: read_value[15:0], position_ok[16], changed_count[29:17],
  // zero fill [31:30].
  output logic      [31:0] m_axis_tdata,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = gff_pkg::AddrBits;
  localparam int IW = gff_pkg::IdBits;
  localparam int CW = gff_pkg::CntBits;
  localparam int EW = gff_pkg::ExtBits;

  // Clamp an extent register to the grid size.
  function automatic logic [EW-1:0] clamp_ext(input logic [EW-1:0] v, input logic [EW-1:0] lim);
    clamp_ext = (v > lim) ? lim : v;
  endfunction

  // Registers and state.
  gff_pkg::state_e state_q, state_d;
  logic [EW-1:0]   rows_q, cols_q;
  logic [EW-1:0]   clr_rows_q, clr_rows_d, clr_cols_q, clr_cols_d;
  logic [AW-1:0]   clr_idx_q, clr_idx_d;
  logic            m_valid_q, m_valid_d;
  logic            out_ok_q, out_ok_d;
  logic            out_rd_q, out_rd_d;
  logic [CW-1:0]   out_cnt_q, out_cnt_d;
  logic [IW-1:0]   new_id_q, new_id_d;
  logic [IW-1:0]   target_q, target_d;
  gff_pkg::pos_t   start_q, start_d;
  gff_pkg::pos_t   cur_q, cur_d;
  gff_pkg::pos_t   nb_pos_q, nb_pos_d;
  logic [2:0]      nb_idx_q, nb_idx_d;
  logic [CW-1:0]   head_q, head_d, tail_q, tail_d, count_q, count_d;

  // Memory ports.
  logic            tile_we, tile_re;
  logic [AW-1:0]   tile_waddr, tile_raddr;
  logic [IW-1:0]   tile_wdata, tile_rdata;
  logic            queue_we, queue_re;
  logic [AW-1:0]   queue_waddr, queue_raddr, queue_wdata, queue_rdata;

  // Handshakes and decode.
  logic            s_fire, m_fire, cfg_we, in_ok;
  logic [EW-1:0]   eff_rows, eff_cols, new_ext;
  gff_pkg::pos_t   in_pos, clr_pos;
  logic [IW-1:0]   in_val;
  gff_pkg::func_e  in_func;
  gff_pkg::reg_e   cfg_reg;

  // Neighbour selection.
  gff_pkg::pos_t   nb_pos [4];
  logic [3:0]      nb_ok;
  logic            nb_found;
  logic [1:0]      nb_sel;
  logic [EW-1:0]   col_p1, row_p1;

  assign eff_rows = clamp_ext(rows_q, EW'(gff_pkg::MaxRows));
  assign eff_cols = clamp_ext(cols_q, EW'(gff_pkg::MaxCols));

  assign in_pos.row = s_axis_tdata[5:0];
  assign in_pos.col = s_axis_tdata[11:6];
  assign in_val     = s_axis_tdata[27:12];
  assign in_func    = gff_pkg::func_e'(s_axis_tuser);
  assign in_ok      = ({1'b0, in_pos.row} < eff_rows) && ({1'b0, in_pos.col} < eff_cols);

  assign s_axis_tready = (state_q == gff_pkg::ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_valid_q && m_axis_tready;

  // Result: the read data comes straight from the tile RAM, which holds it.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_cnt_q, out_ok_q, (out_rd_q ? tile_rdata : IW'(0))};

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_reg = gff_pkg::reg_e'(paddr[2]);
  assign new_ext = clamp_ext(pwdata[EW-1:0], (cfg_reg == gff_pkg::REG_ROWS) ?
                             EW'(gff_pkg::MaxRows) : EW'(gff_pkg::MaxCols));

  always_comb begin
    case (cfg_reg)
      gff_pkg::REG_ROWS: prdata = {{(32-EW){1'b0}}, rows_q};
      gff_pkg::REG_COLS: prdata = {{(32-EW){1'b0}}, cols_q};
      default:           prdata = '0;
    endcase
  end

  // Position under the clearing sweep.
  assign clr_pos = gff_pkg::pos_t'(clr_idx_q);

  // Neighbours of the tile taken from the queue, with their extent checks.
  assign col_p1 = {1'b0, cur_q.col} + EW'(1);
  assign row_p1 = {1'b0, cur_q.row} + EW'(1);

  always_comb begin
    nb_pos[gff_pkg::NbLeft]  = '{row: cur_q.row, col: cur_q.col - 1'b1};
    nb_pos[gff_pkg::NbRight] = '{row: cur_q.row, col: col_p1[gff_pkg::ColBits-1:0]};
    nb_pos[gff_pkg::NbUp]    = '{row: cur_q.row - 1'b1, col: cur_q.col};
    nb_pos[gff_pkg::NbDown]  = '{row: row_p1[gff_pkg::RowBits-1:0], col: cur_q.col};
    nb_ok[gff_pkg::NbLeft]   = (cur_q.col != '0);
    nb_ok[gff_pkg::NbRight]  = (col_p1 < eff_cols);
    nb_ok[gff_pkg::NbUp]     = (cur_q.row != '0);
    nb_ok[gff_pkg::NbDown]   = (row_p1 < eff_rows);
  end

  // First neighbour still to be visited that lies inside the extent.
  always_comb begin
    nb_found = 1'b0;
    nb_sel   = gff_pkg::NbLeft;
    for (int i = 0; i < 4; i++) begin
      if (!nb_found && nb_ok[i] && (3'(i) >= nb_idx_q)) begin
        nb_found = 1'b1;
        nb_sel   = 2'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gff_pkg::ST_CLEAR: begin
        if (clr_idx_q == {AW{1'b1}}) state_d = gff_pkg::ST_IDLE;
      end
      gff_pkg::ST_IDLE: begin
        if (s_fire && in_func == gff_pkg::FUNC_FLOOD && in_ok) state_d = gff_pkg::ST_START;
      end
      gff_pkg::ST_START: begin
        state_d = (tile_rdata == new_id_q) ? gff_pkg::ST_IDLE : gff_pkg::ST_POP;
      end
      gff_pkg::ST_POP: begin
        state_d = (head_q == tail_q) ? gff_pkg::ST_IDLE : gff_pkg::ST_DEQ;
      end
      gff_pkg::ST_DEQ: begin
        state_d = gff_pkg::ST_NREAD;
      end
      gff_pkg::ST_NREAD: begin
        state_d = nb_found ? gff_pkg::ST_NCHECK : gff_pkg::ST_POP;
      end
      gff_pkg::ST_NCHECK: begin
        state_d = gff_pkg::ST_NREAD;
      end
      default: state_d = gff_pkg::ST_IDLE;
    endcase
    // A register write always (re)starts the clearing pass.
    if (cfg_we) state_d = gff_pkg::ST_CLEAR;
  end

  // Memory controls and datapath next values.
  always_comb begin
    tile_we     = 1'b0;
    tile_waddr  = start_q;
    tile_wdata  = new_id_q;
    tile_re     = 1'b0;
    tile_raddr  = in_pos;
    queue_we    = 1'b0;
    queue_waddr = tail_q[AW-1:0];
    queue_wdata = nb_pos_q;
    queue_re    = 1'b0;
    queue_raddr = head_q[AW-1:0];

    m_valid_d   = m_fire ? 1'b0 : m_valid_q;
    out_ok_d    = out_ok_q;
    out_rd_d    = out_rd_q;
    out_cnt_d   = out_cnt_q;
    new_id_d    = new_id_q;
    target_d    = target_q;
    start_d     = start_q;
    cur_d       = cur_q;
    nb_pos_d    = nb_pos_q;
    nb_idx_d    = nb_idx_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    clr_idx_d   = clr_idx_q + 1'b1;
    clr_rows_d  = clr_rows_q;
    clr_cols_d  = clr_cols_q;

    case (state_q)
      // Sweep the grid, zeroing what lies outside the clearing extent.
      gff_pkg::ST_CLEAR: begin
        tile_waddr = clr_idx_q;
        tile_wdata = '0;
        tile_we    = ({1'b0, clr_pos.row} >= clr_rows_q) || ({1'b0, clr_pos.col} >= clr_cols_q);
      end

      // Take a request; everything but an in-extent flood finishes at once.
      gff_pkg::ST_IDLE: begin
        if (s_fire) begin
          m_valid_d  = 1'b1;
          out_ok_d   = in_ok;
          out_rd_d   = 1'b0;
          out_cnt_d  = '0;
          tile_waddr = in_pos;
          tile_wdata = in_val;
          case (in_func)
            gff_pkg::FUNC_READ: begin
              tile_re  = in_ok;
              out_rd_d = in_ok;
            end
            gff_pkg::FUNC_WRITE: begin
              tile_we = in_ok;
            end
            gff_pkg::FUNC_FLOOD: begin
              tile_re   = in_ok;
              m_valid_d = !in_ok;
              new_id_d  = in_val;
              start_d   = in_pos;
            end
            default: begin
            end
          endcase
        end
      end

      // Start tile: stop at once if it already holds the new id.
      gff_pkg::ST_START: begin
        target_d = tile_rdata;
        if (tile_rdata == new_id_q) begin
          m_valid_d = 1'b1;
          out_ok_d  = 1'b1;
          out_rd_d  = 1'b0;
          out_cnt_d = '0;
        end else begin
          tile_we     = 1'b1;
          queue_we    = 1'b1;
          queue_waddr = '0;
          queue_wdata = start_q;
          head_d      = '0;
          tail_d      = CW'(1);
          count_d     = CW'(1);
        end
      end

      // Pop the next tile, or post the count when the queue has run dry.
      gff_pkg::ST_POP: begin
        if (head_q == tail_q) begin
          m_valid_d = 1'b1;
          out_ok_d  = 1'b1;
          out_rd_d  = 1'b0;
          out_cnt_d = count_q;
        end else begin
          queue_re = 1'b1;
          head_d   = head_q + 1'b1;
        end
      end

      gff_pkg::ST_DEQ: begin
        cur_d    = gff_pkg::pos_t'(queue_rdata);
        nb_idx_d = '0;
      end

      // Read the next neighbour inside the extent.
      gff_pkg::ST_NREAD: begin
        tile_raddr = nb_pos[nb_sel];
        tile_re    = nb_found;
        nb_pos_d   = nb_pos[nb_sel];
        nb_idx_d   = {1'b0, nb_sel} + 3'd1;
      end

      // Replace and enqueue the neighbour when it holds the target id.
      gff_pkg::ST_NCHECK: begin
        tile_waddr = nb_pos_q;
        if (tile_rdata == target_q) begin
          tile_we  = 1'b1;
          queue_we = 1'b1;
          tail_d   = tail_q + 1'b1;
          count_d  = count_q + 1'b1;
        end
      end

      default: begin
      end
    endcase

    // A register write restarts the sweep over the smallest extent seen in it.
    if (cfg_we) begin
      clr_idx_d = '0;
      if (state_q == gff_pkg::ST_CLEAR) begin
        if (cfg_reg == gff_pkg::REG_ROWS) begin
          clr_rows_d = (new_ext < clr_rows_q) ? new_ext : clr_rows_q;
          clr_cols_d = (eff_cols < clr_cols_q) ? eff_cols : clr_cols_q;
        end else begin
          clr_rows_d = (eff_rows < clr_rows_q) ? eff_rows : clr_rows_q;
          clr_cols_d = (new_ext < clr_cols_q) ? new_ext : clr_cols_q;
        end
      end else begin
        clr_rows_d = (cfg_reg == gff_pkg::REG_ROWS) ? new_ext : eff_rows;
        clr_cols_d = (cfg_reg == gff_pkg::REG_COLS) ? new_ext : eff_cols;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gff_pkg::ST_CLEAR;
      clr_idx_q  <= '0;
      clr_rows_q <= '0;
      clr_cols_q <= '0;
      m_valid_q  <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      nb_idx_q   <= '0;
    end else begin
      state_q    <= state_d;
      clr_idx_q  <= clr_idx_d;
      clr_rows_q <= clr_rows_d;
      clr_cols_q <= clr_cols_d;
      m_valid_q  <= m_valid_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      nb_idx_q   <= nb_idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_ok_q  <= out_ok_d;
    out_rd_q  <= out_rd_d;
    out_cnt_q <= out_cnt_d;
    new_id_q  <= new_id_d;
    target_q  <= target_d;
    start_q   <= start_d;
    cur_q     <= cur_d;
    nb_pos_q  <= nb_pos_d;
  end

  // Extent registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= EW'(gff_pkg::MaxRows);
      cols_q <= EW'(gff_pkg::MaxCols);
    end else if (cfg_we) begin
      case (cfg_reg)
        gff_pkg::REG_ROWS: rows_q <= pwdata[EW-1:0];
        gff_pkg::REG_COLS: cols_q <= pwdata[EW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Tile grid memory.
  gff_ram #(
    .WIDTH (IW),
    .DEPTH (gff_pkg::Cells)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (tile_waddr),
    .wdata_i (tile_wdata),
    .re_i    (tile_re),
    .raddr_i (tile_raddr),
    .rdata_o (tile_rdata)
  );

  // Fill queue memory.
  gff_ram #(
    .WIDTH (AW),
    .DEPTH (gff_pkg::Cells)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (queue_we),
    .waddr_i (queue_waddr),
    .wdata_i (queue_wdata),
    .re_i    (queue_re),
    .raddr_i (queue_raddr),
    .rdata_o (queue_rdata)
  );

  // Every queued tile was counted once, so count and tail agree during a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gff_pkg::ST_POP || state_q == gff_pkg::ST_DEQ ||
     state_q == gff_pkg::ST_NREAD || state_q == gff_pkg::ST_NCHECK) |-> count_q == tail_q)
    else $error("flood count differs from queue tail");

  // The queue head never overtakes the tail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gff_pkg::ST_POP) |-> head_q <= tail_q)
    else $error("fill queue head beyond tail");

  // An exhausted queue posts the running count as the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gff_pkg::ST_POP && head_q == tail_q && !cfg_we) |=>
      (m_valid_q && out_cnt_q == $past(count_q) && state_q == gff_pkg::ST_IDLE))
    else $error("flood result not posted");

endmodule

`default_nettype wire
